@@ rtl/core/vgrt_pkg.sv @@
// Package for the voxel grid ray traversal block: widths, constants and types.
// Used by the top level, the voxel RAM instance and the port checker.
`timescale 1ns / 1ps

package vgrt_pkg;

    // Grid geometry; each axis is a power of two so an address is {x, y, z}.
    localparam int COORD_W     = 5;
    localparam int GRID_X      = 1 << COORD_W;
    localparam int GRID_Y      = 1 << COORD_W;
    localparam int GRID_Z      = 1 << COORD_W;
    localparam int ADDR_W      = 3 * COORD_W;
    localparam int VOXEL_COUNT = GRID_X * GRID_Y * GRID_Z;
    localparam int TYPE_W      = 8;

    // Fixed-point formats.
    localparam int FRAC_BITS = 16;
    localparam int ORG_W     = 24;
    localparam int DIR_W     = 18;
    localparam int MAXD_W    = 24;
    localparam int DIST_W    = 40;
    localparam int QUO_W     = 2 * FRAC_BITS + 1;
    localparam int GAP_W     = FRAC_BITS + 1;
    localparam int REM_W     = DIR_W - 1;
    localparam int POS_W     = 12;
    localparam int HALF_W    = DIST_W / 2;
    localparam int ACC_W     = GAP_W + DIST_W;
    localparam int CNT_W     = 6;

    localparam logic [DIST_W-1:0] DIST_CAP   = {DIST_W{1'b1}};
    localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(393216);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_WALK,
        ST_WAIT,
        ST_DONE
    } state_t;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RAY   = 1'b1;

    // Face codes: the step that entered the hit voxel.
    typedef enum logic [2:0] {
        FACE_NONE = 3'd0,
        FACE_PX   = 3'd1,
        FACE_NX   = 3'd2,
        FACE_PY   = 3'd3,
        FACE_NY   = 3'd4,
        FACE_PZ   = 3'd5,
        FACE_NZ   = 3'd6
    } face_t;

endpackage

@@ rtl/core/vgrt_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module vgrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/voxel_grid_ray_traversal.sv @@
// Top level of the voxel grid ray traversal block: sequencer, reciprocal
// lanes, side-distance multiplier and DDA walk. Depends on vgrt_pkg, vgrt_ram.
`timescale 1ns / 1ps

// After reset the block sweeps the 32768-entry voxel RAM to empty, one entry
// per cycle, and takes no item until the sweep is done (configuration writes
// are taken at any time). A write item goes to the RAM as it is taken. A ray
// item first computes the three reciprocals (bit-serial restoring dividers,
// one per axis, running side by side), then the side distances (delta is
// latched, then one shared 17x20 multiplier makes two passes per axis), then
// walks: each cell examined inside the grid takes one RAM read, and a cell
// outside the grid is stepped over without one; the result is then posted
// once the output register is free. A walk also ends at the distance limit.
// A new item is taken once the result is in the output register, even if
// that result has not been taken.
module voxel_grid_ray_traversal
    import vgrt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input item channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic [COORD_W-1:0]       voxel_x,
    input  logic [COORD_W-1:0]       voxel_y,
    input  logic [COORD_W-1:0]       voxel_z,
    input  logic [TYPE_W-1:0]        voxel_type,
    input  logic signed [ORG_W-1:0]  origin_x,
    input  logic signed [ORG_W-1:0]  origin_y,
    input  logic signed [ORG_W-1:0]  origin_z,
    input  logic signed [DIR_W-1:0]  dir_x,
    input  logic signed [DIR_W-1:0]  dir_y,
    input  logic signed [DIR_W-1:0]  dir_z,
    // Result item channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [COORD_W-1:0]       hit_x,
    output logic [COORD_W-1:0]       hit_y,
    output logic [COORD_W-1:0]       hit_z,
    output logic [TYPE_W-1:0]        hit_type,
    output logic                     has_place,
    output logic [COORD_W-1:0]       place_x,
    output logic [COORD_W-1:0]       place_y,
    output logic [COORD_W-1:0]       place_z,
    output logic [2:0]               face,
    // Configuration
    input  logic                     cfg_we,
    input  logic [MAXD_W-1:0]        cfg_wdata
);

    state_t state_reg, state_next;

    logic [MAXD_W-1:0]       max_distance_reg;
    logic [ADDR_W-1:0]       clear_cnt_reg;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic [1:0]              mul_lane_reg;
    logic                    mul_phase_reg;
    logic [ACC_W-1:0]        acc_reg;

    // Per-axis lanes
    logic signed [POS_W-1:0] pos_reg   [3];
    logic signed [POS_W-1:0] prev_reg  [3];
    logic [GAP_W-1:0]        gap_reg   [3];
    logic [DIR_W-1:0]        mag_reg   [3];
    logic                    pos_dir_reg [3];
    logic                    neg_dir_reg [3];
    logic [REM_W-1:0]        rem_reg   [3];
    logic [QUO_W-1:0]        quo_reg   [3];
    logic [DIST_W-1:0]       delta_reg [3];
    logic [DIST_W-1:0]       side_reg  [3];

    logic [DIST_W-1:0]       dist_reg;
    logic                    moved_reg;
    logic [1:0]              last_axis_reg;
    logic                    hit_reg;
    logic [TYPE_W-1:0]       type_reg;

    logic                    out_valid_reg;
    logic                    hit_out_reg;
    logic [COORD_W-1:0]      hit_x_reg, hit_y_reg, hit_z_reg;
    logic [TYPE_W-1:0]       hit_type_reg;
    logic                    has_place_reg;
    logic [COORD_W-1:0]      place_x_reg, place_y_reg, place_z_reg;
    face_t                   face_reg;

    // Input lanes as arrays
    logic signed [ORG_W-1:0] org_in [3];
    logic signed [DIR_W-1:0] dir_in [3];

    // RAM port signals
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [TYPE_W-1:0]       ram_wdata;
    logic                    ram_re;
    logic [TYPE_W-1:0]       ram_rdata;

    // Walk control
    logic                    accept;
    logic                    slot_free;
    logic                    pos_in_grid;
    logic                    prev_in_grid;
    logic                    dist_ok;
    logic                    do_step;
    logic [1:0]              step_axis;
    logic [DIST_W:0]         step_sum;
    logic [DIST_W-1:0]       step_side;

    // Multiplier
    logic [HALF_W-1:0]       mul_part;
    logic [GAP_W+HALF_W-1:0] mul_prod;
    logic [ACC_W-1:0]        acc_sum;
    logic [ACC_W-FRAC_BITS-1:0] side_full;
    logic [DIST_W-1:0]       side_sat;

    face_t                   face_code;

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Grid tests: a cell is inside when its signed coordinate is in [0, 32).
    assign pos_in_grid = (pos_reg[0][POS_W-1:COORD_W] == '0)
                      && (pos_reg[1][POS_W-1:COORD_W] == '0)
                      && (pos_reg[2][POS_W-1:COORD_W] == '0);
    assign prev_in_grid = (prev_reg[0][POS_W-1:COORD_W] == '0)
                       && (prev_reg[1][POS_W-1:COORD_W] == '0)
                       && (prev_reg[2][POS_W-1:COORD_W] == '0);
    assign dist_ok = (dist_reg < {{(DIST_W-MAXD_W){1'b0}}, max_distance_reg});

    // A step happens when the current cell is empty: outside the grid right away
    // (while under the distance limit), inside the grid once the read data is back and zero.
    always_comb
    begin
        do_step = 1'b0;
        if (state_reg == ST_WALK)
        begin
            do_step = dist_ok && !pos_in_grid;
        end
        else if (state_reg == ST_WAIT)
        begin
            do_step = (ram_rdata == '0);
        end
    end

    // Pick the axis with the smallest side distance; ties go to the later axis (z over y over x).
    always_comb
    begin
        if (side_reg[0] < side_reg[1])
        begin
            step_axis = (side_reg[0] < side_reg[2]) ? 2'd0 : 2'd2;
        end
        else
        begin
            step_axis = (side_reg[1] < side_reg[2]) ? 2'd1 : 2'd2;
        end
        step_sum  = {1'b0, side_reg[step_axis]} + {1'b0, delta_reg[step_axis]};
        step_side = step_sum[DIST_W] ? DIST_CAP : step_sum[DIST_W-1:0];
    end

    // Side distance: gap times delta, one half of delta per pass.
    always_comb
    begin
        mul_part  = mul_phase_reg ? delta_reg[mul_lane_reg][DIST_W-1:HALF_W]
                                  : delta_reg[mul_lane_reg][HALF_W-1:0];
        mul_prod  = gap_reg[mul_lane_reg] * mul_part;
        acc_sum   = acc_reg + (mul_phase_reg ? (ACC_W'(mul_prod) << HALF_W)
                                             : ACC_W'(mul_prod));
        side_full = acc_sum[ACC_W-1:FRAC_BITS];
        side_sat  = (side_full > {{(ACC_W-FRAC_BITS-DIST_W){1'b0}}, DIST_CAP})
                    ? DIST_CAP : side_full[DIST_W-1:0];
    end

    // Face code from the last step taken.
    always_comb
    begin
        face_code = FACE_NONE;
        if (moved_reg)
        begin
            case (last_axis_reg)
                2'd0:
                begin
                    if (pos_reg[0] != prev_reg[0])
                    begin
                        face_code = pos_dir_reg[0] ? FACE_PX : FACE_NX;
                    end
                end
                2'd1:
                begin
                    if (pos_reg[1] != prev_reg[1])
                    begin
                        face_code = pos_dir_reg[1] ? FACE_PY : FACE_NY;
                    end
                end
                2'd2:
                begin
                    if (pos_reg[2] != prev_reg[2])
                    begin
                        face_code = pos_dir_reg[2] ? FACE_PZ : FACE_NZ;
                    end
                end
                default:
                begin
                    face_code = FACE_NONE;
                end
            endcase
        end
    end

    // RAM ports: clearing sweep, voxel writes, and walk reads.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clear_cnt_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (accept && func == FUNC_WRITE)
        begin
            ram_we    = 1'b1;
            ram_waddr = {voxel_x, voxel_y, voxel_z};
            ram_wdata = voxel_type;
        end
        ram_re = (state_reg == ST_WALK) && dist_ok && pos_in_grid;
    end

    vgrt_ram #(
        .WIDTH (TYPE_W),
        .DEPTH (VOXEL_COUNT)
    ) u_voxel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr ({pos_reg[0][COORD_W-1:0], pos_reg[1][COORD_W-1:0],
                 pos_reg[2][COORD_W-1:0]}),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == ADDR_W'(VOXEL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && func == FUNC_RAY)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_phase_reg && mul_lane_reg == 2'd2)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!dist_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (pos_in_grid)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = (ram_rdata != '0) ? ST_DONE : ST_WALK;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clear_cnt_reg    <= '0;
            max_distance_reg <= MAXD_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                max_distance_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Ray datapath.
    always_ff @(posedge clk)
    begin
        // Ray setup: cell, gap to the first border, direction magnitude.
        if (accept && func == FUNC_RAY)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]     <= POS_W'(org_in[i] >>> FRAC_BITS);
                pos_dir_reg[i] <= !dir_in[i][DIR_W-1] && (dir_in[i] != '0);
                neg_dir_reg[i] <= dir_in[i][DIR_W-1];
                mag_reg[i]     <= dir_in[i][DIR_W-1] ? DIR_W'(-dir_in[i])
                                                     : DIR_W'(dir_in[i]);
                if (!dir_in[i][DIR_W-1] && (dir_in[i] != '0))
                begin
                    gap_reg[i] <= GAP_W'(1 << FRAC_BITS)
                                - GAP_W'(org_in[i][FRAC_BITS-1:0]);
                end
                else
                begin
                    gap_reg[i] <= GAP_W'(org_in[i][FRAC_BITS-1:0]);
                end
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
            div_cnt_reg <= CNT_W'(QUO_W - 1);
        end

        // Reciprocal lanes: 2^(2F) / magnitude, one quotient bit per cycle.
        if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ({rem_reg[i], (div_cnt_reg == CNT_W'(QUO_W - 1))} >= mag_reg[i])
                begin
                    rem_reg[i] <= REM_W'({rem_reg[i], (div_cnt_reg == CNT_W'(QUO_W - 1))}
                                         - mag_reg[i]);
                    quo_reg[i] <= {quo_reg[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= REM_W'({rem_reg[i], (div_cnt_reg == CNT_W'(QUO_W - 1))});
                    quo_reg[i] <= {quo_reg[i][QUO_W-2:0], 1'b0};
                end
            end
            div_cnt_reg <= div_cnt_reg - 1'b1;
            mul_lane_reg  <= 2'd0;
            mul_phase_reg <= 1'b0;
            acc_reg       <= '0;
        end

        // Delta follows the last quotient bit; a zero component saturates.
        if (state_reg == ST_MUL && mul_lane_reg == 2'd0 && !mul_phase_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                delta_reg[i] <= (mag_reg[i] == '0) ? DIST_CAP : DIST_W'(quo_reg[i]);
            end
        end

        // Side distance passes; the first pass waits on delta of lane zero.
        if (state_reg == ST_MUL)
        begin
            if (mul_lane_reg == 2'd0 && !mul_phase_reg && !moved_reg)
            begin
                moved_reg <= 1'b1;
            end
            else if (!mul_phase_reg)
            begin
                acc_reg       <= acc_sum;
                mul_phase_reg <= 1'b1;
            end
            else
            begin
                side_reg[mul_lane_reg] <= side_sat;
                acc_reg       <= '0;
                mul_phase_reg <= 1'b0;
                mul_lane_reg  <= mul_lane_reg + 1'b1;
                if (mul_lane_reg == 2'd2)
                begin
                    moved_reg <= 1'b0;
                    dist_reg  <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        prev_reg[i] <= pos_reg[i];
                    end
                end
            end
        end
        else if (state_reg == ST_DIV)
        begin
            moved_reg <= 1'b0;
        end

        // One DDA step along the chosen axis.
        if (do_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= pos_reg[i];
            end
            if (pos_dir_reg[step_axis])
            begin
                pos_reg[step_axis] <= pos_reg[step_axis] + POS_W'(1);
            end
            else if (neg_dir_reg[step_axis])
            begin
                pos_reg[step_axis] <= pos_reg[step_axis] - POS_W'(1);
            end
            side_reg[step_axis] <= step_side;
            dist_reg      <= side_reg[step_axis];
            last_axis_reg <= step_axis;
            moved_reg     <= 1'b1;
        end

        // End of the walk: a hit or a miss.
        if (state_reg == ST_WALK && !dist_ok)
        begin
            hit_reg <= 1'b0;
        end
        else if (state_reg == ST_WAIT && ram_rdata != '0)
        begin
            hit_reg  <= 1'b1;
            type_reg <= ram_rdata;
        end

        // Result item into the output register.
        if (state_reg == ST_DONE && slot_free)
        begin
            hit_out_reg   <= hit_reg;
            hit_x_reg     <= hit_reg ? pos_reg[0][COORD_W-1:0] : '0;
            hit_y_reg     <= hit_reg ? pos_reg[1][COORD_W-1:0] : '0;
            hit_z_reg     <= hit_reg ? pos_reg[2][COORD_W-1:0] : '0;
            hit_type_reg  <= hit_reg ? type_reg : '0;
            has_place_reg <= hit_reg && moved_reg && prev_in_grid;
            if (hit_reg && moved_reg && prev_in_grid)
            begin
                place_x_reg <= prev_reg[0][COORD_W-1:0];
                place_y_reg <= prev_reg[1][COORD_W-1:0];
                place_z_reg <= prev_reg[2][COORD_W-1:0];
            end
            else
            begin
                place_x_reg <= '0;
                place_y_reg <= '0;
                place_z_reg <= '0;
            end
            face_reg <= hit_reg ? face_code : FACE_NONE;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_out_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;
    assign hit_z     = hit_z_reg;
    assign hit_type  = hit_type_reg;
    assign has_place = has_place_reg;
    assign place_x   = place_x_reg;
    assign place_y   = place_y_reg;
    assign place_z   = place_z_reg;
    assign face      = face_reg;

endmodule

@@ rtl/core/vgrt_checker.sv @@
// Port-level checks for the voxel grid ray traversal block, bound to the top.
// Depends on vgrt_pkg.
`timescale 1ns / 1ps

module vgrt_checker
    import vgrt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               func,
    input logic               out_valid,
    input logic               out_ready,
    input logic               hit,
    input logic [COORD_W-1:0] hit_x,
    input logic [TYPE_W-1:0]  hit_type,
    input logic               has_place,
    input logic [COORD_W-1:0] place_x,
    input logic [2:0]         face
);

    // A result item waits until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    // A ray item occupies the block for at least the next cycle.
    a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_RAY |=> !in_ready)
        else $error("block took an item right after a ray");

    // A miss reports hit_x, hit_type, has_place and face as zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_x == '0 && hit_type == '0 && !has_place
                             && face == FACE_NONE)
        else $error("miss item with nonzero fields");

    // A place position implies a hit entered through a face.
    a_place_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_place |-> hit && face != FACE_NONE)
        else $error("place position without a hit face");

    // No place position means a zero place_x.
    a_place_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_place |-> place_x == '0)
        else $error("place coordinates set without a place position");

endmodule

bind voxel_grid_ray_traversal vgrt_checker u_vgrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .hit_x     (hit_x),
    .hit_type  (hit_type),
    .has_place (has_place),
    .place_x   (place_x),
    .face      (face)
);
